// ----- hw/rtl/mtdp_pkg.sv -----
package mtdp_pkg;

   localparam int REQ_W  = 3;
   localparam int CH_W   = 3;
   localparam int MS_W   = 31;
   localparam int VOL_W  = 32;
   localparam int ST_W   = 2;
   localparam int MASK_W = 6;
   localparam int IDX_W  = 3;

   localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

   // request codes
   localparam logic [REQ_W-1:0] REQ_DOSE_TIME = 3'd0;
   localparam logic [REQ_W-1:0] REQ_DOSE_VOL  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_TICK      = 3'd2;
   localparam logic [REQ_W-1:0] REQ_MAN_ON    = 3'd3;
   localparam logic [REQ_W-1:0] REQ_MAN_OFF   = 3'd4;

   // response status codes
   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
   localparam logic [ST_W-1:0] ST_BUSY    = 2'd2;

   typedef struct packed {
      logic exec;        // commit a request that needs no division and load the response
      logic div_start;   // launch the volume-to-time division
      logic div_commit;  // commit the division result and load the response
   } dp_cmd_type;

   typedef struct packed {
      logic needs_div;   // the offered request is a volume dose that must divide
      logic div_done;    // quotient is ready
   } dp_stat_type;

endpackage

// ----- hw/rtl/mtdp_div.sv -----
module mtdp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mtdp_pkg::VOL_W-1:0]  dividend,
   input  logic [mtdp_pkg::VOL_W-1:0]  divisor,
   output logic                        done,
   output logic [mtdp_pkg::VOL_W-1:0]  quotient
);

   localparam int W     = mtdp_pkg::VOL_W;
   localparam int CNT_W = $clog2(W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     dvs_ff, dvs_in;

   logic [W:0]       shifted;
   logic [W:0]       diff;
   logic             ge;

   // one restoring step per cycle: shift in the next dividend bit, try subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = ~diff[W];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hw/rtl/mtdp_dp.sv -----
module mtdp_dp #(
   parameter int CHANNELS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mtdp_pkg::dp_cmd_type          cmd,
   output mtdp_pkg::dp_stat_type         stat,
   input  logic                          csr_we,
   input  logic [mtdp_pkg::IDX_W-1:0]    csr_index,
   input  logic [mtdp_pkg::VOL_W-1:0]    csr_wdata,
   input  logic [mtdp_pkg::REQ_W-1:0]    req_type,
   input  logic [mtdp_pkg::CH_W-1:0]     req_channel,
   input  logic [mtdp_pkg::MS_W-1:0]     req_duration_ms,
   input  logic [mtdp_pkg::VOL_W-1:0]    req_volume,
   output logic [mtdp_pkg::ST_W-1:0]     rsp_status,
   output logic [mtdp_pkg::MASK_W-1:0]   rsp_pump_levels,
   output logic [mtdp_pkg::MASK_W-1:0]   rsp_busy_mask,
   output logic [mtdp_pkg::MASK_W-1:0]   rsp_finished_mask,
   output logic                          rsp_any_busy
);

   localparam int MS_W   = mtdp_pkg::MS_W;
   localparam int VOL_W  = mtdp_pkg::VOL_W;
   localparam int MASK_W = mtdp_pkg::MASK_W;

   logic [VOL_W-1:0]    speed_ff [CHANNELS];
   logic [CHANNELS-1:0] run_ff, run_in;
   logic [CHANNELS-1:0] lvl_ff, lvl_in;
   logic [MS_W-1:0]     rem_ff [CHANNELS];
   logic [MS_W-1:0]     rem_in [CHANNELS];
   logic [CHANNELS-1:0] dsel_ff, dsel_in;

   logic [mtdp_pkg::ST_W-1:0] st_ff, st_in;
   logic [MASK_W-1:0]         lvl_out_ff, busy_out_ff, fin_out_ff;
   logic [CHANNELS-1:0]       fin_in;
   logic                      any_ff;

   logic [CHANNELS-1:0] sel;
   logic                ch_ok;
   logic                sel_run;
   logic [VOL_W-1:0]    spd_sel;
   logic [MS_W-1:0]     rem_dec;
   logic [VOL_W-1:0]    quo;
   logic [MS_W-1:0]     quo_ms;
   logic                div_done;
   logic                load;

   always_comb begin
      spd_sel = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         sel[i] = (req_channel == mtdp_pkg::CH_W'(i));
         if (sel[i]) spd_sel = speed_ff[i];
      end
      ch_ok   = (req_channel < mtdp_pkg::CH_W'(CHANNELS));
      sel_run = |(sel & run_ff);
   end

   assign stat.needs_div = (req_type == mtdp_pkg::REQ_DOSE_VOL) && ch_ok
                           && (req_volume != '0) && !sel_run && (spd_sel != '0);
   assign stat.div_done  = div_done;

   mtdp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (req_volume),
      .divisor  (spd_sel),
      .done     (div_done),
      .quotient (quo)
   );

   // saturate long quotients to the largest run time
   assign quo_ms = (quo > {1'b0, mtdp_pkg::MS_MAX}) ? mtdp_pkg::MS_MAX : quo[MS_W-1:0];

   always_comb begin
      run_in  = run_ff;
      lvl_in  = lvl_ff;
      rem_in  = rem_ff;
      fin_in  = '0;
      st_in   = mtdp_pkg::ST_OK;
      dsel_in = cmd.div_start ? sel : dsel_ff;
      rem_dec = '0;

      if (cmd.exec) begin
         case (req_type)
            mtdp_pkg::REQ_DOSE_TIME: begin
               if (!ch_ok || req_duration_ms == '0) begin
                  st_in = mtdp_pkg::ST_INVALID;
               end else if (sel_run) begin
                  st_in = mtdp_pkg::ST_BUSY;
               end else begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     if (sel[i]) begin
                        run_in[i] = 1'b1;
                        lvl_in[i] = 1'b1;
                        rem_in[i] = req_duration_ms;
                     end
                  end
               end
            end
            mtdp_pkg::REQ_DOSE_VOL: begin
               // only rejections get here; accepted volume doses go through the divider
               if (ch_ok && req_volume != '0 && sel_run) st_in = mtdp_pkg::ST_BUSY;
               else st_in = mtdp_pkg::ST_INVALID;
            end
            mtdp_pkg::REQ_TICK: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (run_ff[i]) begin
                     rem_dec   = (rem_ff[i] == '0) ? '0 : rem_ff[i] - 1'b1;
                     rem_in[i] = rem_dec;
                     if (rem_dec == '0) begin
                        run_in[i] = 1'b0;
                        lvl_in[i] = 1'b0;
                        fin_in[i] = 1'b1;
                     end
                  end
               end
            end
            mtdp_pkg::REQ_MAN_ON: begin
               if (!ch_ok) st_in = mtdp_pkg::ST_INVALID;
               else if (sel_run) st_in = mtdp_pkg::ST_BUSY;
               else lvl_in = lvl_ff | sel;
            end
            mtdp_pkg::REQ_MAN_OFF: begin
               if (!ch_ok) st_in = mtdp_pkg::ST_INVALID;
               else lvl_in = lvl_ff & ~sel;
            end
            default: begin
               st_in = mtdp_pkg::ST_INVALID;
            end
         endcase
      end else if (cmd.div_commit) begin
         if (quo == '0) begin
            st_in = mtdp_pkg::ST_INVALID;
         end else begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (dsel_ff[i]) begin
                  run_in[i] = 1'b1;
                  lvl_in[i] = 1'b1;
                  rem_in[i] = quo_ms;
               end
            end
         end
      end
   end

   assign load = cmd.exec | cmd.div_commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
         lvl_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            speed_ff[i] <= '0;
            rem_ff[i]   <= '0;
         end
      end else begin
         run_ff <= run_in;
         lvl_ff <= lvl_in;
         rem_ff <= rem_in;
         for (int i = 0; i < CHANNELS; i++) begin
            if (csr_we && csr_index == mtdp_pkg::IDX_W'(i)) speed_ff[i] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      dsel_ff <= dsel_in;
      if (load) begin
         st_ff       <= st_in;
         lvl_out_ff  <= MASK_W'(lvl_in);
         busy_out_ff <= MASK_W'(run_in);
         fin_out_ff  <= MASK_W'(fin_in);
         any_ff      <= |run_in;
      end
   end

   assign rsp_status        = st_ff;
   assign rsp_pump_levels   = lvl_out_ff;
   assign rsp_busy_mask     = busy_out_ff;
   assign rsp_finished_mask = fin_out_ff;
   assign rsp_any_busy      = any_ff;

endmodule

// ----- hw/rtl/mtdp_ctrl.sv -----
module mtdp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mtdp_pkg::dp_stat_type  stat,
   output mtdp_pkg::dp_cmd_type   cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      req_fire;

   // the response register is free when empty or draining this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in       = state_ff;
      cmd.exec       = 1'b0;
      cmd.div_start  = 1'b0;
      cmd.div_commit = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (stat.needs_div) begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end else begin
                  cmd.exec     = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_DIV: begin
            if (stat.div_done) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            // hold the quotient until the response register can take the result
            if (out_free) begin
               cmd.div_commit = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/multichannel_timed_dosing_pump_top.sv -----
// Channel   Handshake               Payload
// request   req_valid / req_ready   req_type, req_channel, req_duration_ms, req_volume
// response  rsp_valid / rsp_ready   rsp_status, rsp_pump_levels, rsp_busy_mask,
//                                   rsp_finished_mask, rsp_any_busy
// config    csr_we                  csr_index, csr_wdata (speed_ch0..speed_ch5)
//
// Ticks, timed doses, manual commands and rejections: result registered in the cycle after accept.
// Accepted volume doses: bit-serial 32-bit divider (one bit/cycle) in S_DIV, then commit in S_COMMIT.
// One request at a time; a new one is taken while the previous response drains.
// Synchronous reset clears all channel state and speed registers, but not the response registers.
// A stalled response holds its register; a finished division waits for it to drain.
module multichannel_timed_dosing_pump_top #(
   parameter int CHANNELS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mtdp_pkg::REQ_W-1:0]    req_type,
   input  logic [mtdp_pkg::CH_W-1:0]     req_channel,
   input  logic [mtdp_pkg::MS_W-1:0]     req_duration_ms,
   input  logic [mtdp_pkg::VOL_W-1:0]    req_volume,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mtdp_pkg::ST_W-1:0]     rsp_status,
   output logic [mtdp_pkg::MASK_W-1:0]   rsp_pump_levels,
   output logic [mtdp_pkg::MASK_W-1:0]   rsp_busy_mask,
   output logic [mtdp_pkg::MASK_W-1:0]   rsp_finished_mask,
   output logic                          rsp_any_busy,
   input  logic                          csr_we,
   input  logic [mtdp_pkg::IDX_W-1:0]    csr_index,
   input  logic [mtdp_pkg::VOL_W-1:0]    csr_wdata
);

   mtdp_pkg::dp_cmd_type  cmd;
   mtdp_pkg::dp_stat_type stat;

   mtdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mtdp_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_type          (req_type),
      .req_channel       (req_channel),
      .req_duration_ms   (req_duration_ms),
      .req_volume        (req_volume),
      .rsp_status        (rsp_status),
      .rsp_pump_levels   (rsp_pump_levels),
      .rsp_busy_mask     (rsp_busy_mask),
      .rsp_finished_mask (rsp_finished_mask),
      .rsp_any_busy      (rsp_any_busy)
   );

endmodule
